// ===== hdl/hpfc_pkg.sv =====
// Package for the heading PD fan controller: register codes, stage payload
// types and the fixed constants of the control law. No dependencies.
package hpfc_pkg;

   localparam int HEADING_W  = 12;
   localparam int RANGE_W    = 16;
   localparam int GAIN_W     = 10;
   localparam int PULSE_W    = 12;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   localparam int FULL_TURN     = 3600;
   localparam int HALF_TURN     = 1800;
   localparam int SHIFT_STEP    = 72;
   localparam int RANGE_MAX     = 50;
   localparam int RANGE_MID     = 25;
   localparam int PULSE_NEUTRAL = 2750;
   localparam int PULSE_MIN     = 2000;
   localparam int PULSE_MAX     = 3500;

   // ceil(2^24 / 10); exact floor(m / 10) for m below 2^21
   localparam int RECIP_TEN       = 1677722;
   localparam int RECIP_TEN_SHIFT = 24;

   localparam int PMAG_W  = 21;
   localparam int DTERM_W = 23;
   localparam int SUM_W   = 25;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TARGET_HEADING = 2'd0,
      CSR_PROP_GAIN      = 2'd1,
      CSR_DERIV_GAIN     = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [HEADING_W-1:0] target_heading;
      logic [GAIN_W-1:0]    prop_gain;
      logic [GAIN_W-1:0]    deriv_gain;
   } cfg_type;

   // error stage to drive stage
   typedef struct packed {
      logic signed [HEADING_W-1:0] heading_error;
      logic signed [HEADING_W-1:0] target_shift;
      logic                        p_neg;
      logic [PMAG_W-1:0]           p_mag;
      logic signed [DTERM_W-1:0]   d_term;
   } err_stage_type;

endpackage

// ===== hdl/heading_pd_fan_controller.sv =====
// Top level of the heading PD fan controller: configuration registers,
// error stage and drive stage. Depends on hpfc_pkg, hpfc_csr, hpfc_front, hpfc_drive.
//
//   port group  dir  transfer when           payload
//   req_        in   req_valid & req_ready   measured_heading, range_reading
//   rsp_        out  rsp_valid & rsp_ready   right/left_pulse, heading_error, target_shift
//   csr_        in   csr_valid & csr_ready   csr_index, csr_data
//
// One item per cycle sustained while rsp_ready is high; each request passes through the
// input register, the error/product register and the result register.
// Synchronous active-high reset clears valids, configuration and the previous error.
// A stalled result holds the stages behind it; ready propagates back combinationally.
// csr_ready is always high.
module heading_pd_fan_controller (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [hpfc_pkg::HEADING_W-1:0]        req_measured_heading,
   input  logic [hpfc_pkg::RANGE_W-1:0]          req_range_reading,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [hpfc_pkg::PULSE_W-1:0]          rsp_right_pulse,
   output logic [hpfc_pkg::PULSE_W-1:0]          rsp_left_pulse,
   output logic signed [hpfc_pkg::HEADING_W-1:0] rsp_heading_error,
   output logic signed [hpfc_pkg::HEADING_W-1:0] rsp_target_shift,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [hpfc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [hpfc_pkg::CSR_DATA_W-1:0]       csr_data
);
   import hpfc_pkg::*;

   cfg_type       cfg;
   logic          err_valid, err_ready;
   err_stage_type err_data;

   hpfc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   hpfc_front u_front (
      .clock                (clock),
      .reset                (reset),
      .cfg                  (cfg),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_measured_heading (req_measured_heading),
      .req_range_reading    (req_range_reading),
      .err_valid            (err_valid),
      .err_ready            (err_ready),
      .err_data             (err_data)
   );

   hpfc_drive u_drive (
      .clock             (clock),
      .reset             (reset),
      .err_valid         (err_valid),
      .err_ready         (err_ready),
      .err_data          (err_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_right_pulse   (rsp_right_pulse),
      .rsp_left_pulse    (rsp_left_pulse),
      .rsp_heading_error (rsp_heading_error),
      .rsp_target_shift  (rsp_target_shift)
   );

endmodule

// ===== hdl/hpfc_csr.sv =====
// Configuration registers of the heading PD fan controller.
// Depends on hpfc_pkg.
module hpfc_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [hpfc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [hpfc_pkg::CSR_DATA_W-1:0]    csr_data,
   output hpfc_pkg::cfg_type                  cfg
);
   import hpfc_pkg::*;

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_TARGET_HEADING: cfg_in.target_heading = csr_data[HEADING_W-1:0];
            CSR_PROP_GAIN:      cfg_in.prop_gain      = csr_data[GAIN_W-1:0];
            CSR_DERIV_GAIN:     cfg_in.deriv_gain     = csr_data[GAIN_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== hdl/hpfc_front.sv =====
// Input register, target shift and heading error, P and D products.
// Keeps the previous error. Depends on hpfc_pkg.
module hpfc_front (
   input  logic                               clock,
   input  logic                               reset,
   input  hpfc_pkg::cfg_type                  cfg,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [hpfc_pkg::HEADING_W-1:0]     req_measured_heading,
   input  logic [hpfc_pkg::RANGE_W-1:0]       req_range_reading,
   output logic                               err_valid,
   input  logic                               err_ready,
   output hpfc_pkg::err_stage_type            err_data
);
   import hpfc_pkg::*;

   logic                        in_v_ff, in_v_in;
   logic [HEADING_W-1:0]        heading_ff;
   logic [RANGE_W-1:0]          range_ff;
   logic                        es_v_ff, es_v_in;
   err_stage_type               es_ff;
   logic signed [HEADING_W-1:0] last_error_ff;

   logic                        in_load, in_move, es_free;
   logic                        in_band;
   logic signed [6:0]           steps;
   logic signed [12:0]          shift_wide;
   logic signed [HEADING_W-1:0] shift;
   logic signed [13:0]          goal_sum, goal, err_raw, err_wrap;
   logic signed [HEADING_W-1:0] err;
   logic signed [12:0]          err_delta;
   logic signed [DTERM_W-1:0]   p_full, p_abs;
   err_stage_type               es_in;

   assign es_free   = !es_v_ff || err_ready;
   assign in_move   = in_v_ff && es_free;
   assign req_ready = !in_v_ff || in_move;
   assign in_load   = req_valid && req_ready;
   assign in_v_in   = in_load ? 1'b1 : (in_move ? 1'b0 : in_v_ff);
   assign es_v_in   = in_move ? 1'b1 : (err_ready ? 1'b0 : es_v_ff);

   always_comb begin
      in_band    = (range_ff >= RANGE_W'(1)) && (range_ff <= RANGE_W'(RANGE_MAX));
      steps      = 7'(RANGE_MID) - $signed({1'b0, range_ff[5:0]});
      shift_wide = 13'(steps) * 13'(SHIFT_STEP);
      shift      = in_band ? shift_wide[HEADING_W-1:0] : '0;

      goal_sum = $signed({2'b00, cfg.target_heading}) + 14'(shift);
      if (goal_sum < 0) begin
         goal = goal_sum + 14'(FULL_TURN);
      end else if (goal_sum >= 14'(FULL_TURN)) begin
         goal = goal_sum - 14'(FULL_TURN);
      end else begin
         goal = goal_sum;
      end

      err_raw = goal - $signed({2'b00, heading_ff});
      if (err_raw < -14'(HALF_TURN)) begin
         err_wrap = err_raw + 14'(FULL_TURN);
      end else if (err_raw > 14'(HALF_TURN)) begin
         err_wrap = err_raw - 14'(FULL_TURN);
      end else begin
         err_wrap = err_raw;
      end
      err = err_wrap[HEADING_W-1:0];

      err_delta = 13'(err) - 13'(last_error_ff);
      p_full    = DTERM_W'(err) * DTERM_W'($signed({1'b0, cfg.prop_gain}));
      p_abs     = err[HEADING_W-1] ? -p_full : p_full;

      es_in.heading_error = err;
      es_in.target_shift  = shift;
      es_in.p_neg         = err[HEADING_W-1];
      es_in.p_mag         = p_abs[PMAG_W-1:0];
      es_in.d_term        = DTERM_W'(err_delta) * DTERM_W'($signed({1'b0, cfg.deriv_gain}));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff       <= 1'b0;
         es_v_ff       <= 1'b0;
         last_error_ff <= '0;
      end else begin
         in_v_ff <= in_v_in;
         es_v_ff <= es_v_in;
         if (in_move) begin
            last_error_ff <= err;
         end
      end
      if (in_load) begin
         heading_ff <= req_measured_heading;
         range_ff   <= req_range_reading;
      end
      if (in_move) begin
         es_ff <= es_in;
      end
   end

   assign err_valid = es_v_ff;
   assign err_data  = es_ff;

   a_last_error_tracks : assert property (@(posedge clock) disable iff (reset)
      $past(in_move) |-> (last_error_ff == es_ff.heading_error))
      else $error("previous error not taken from the last item");

   a_error_wrapped : assert property (@(posedge clock) disable iff (reset)
      es_v_ff |-> (es_ff.heading_error >= -12'sd1800 && es_ff.heading_error <= 12'sd1800))
      else $error("heading error outside half turn");

endmodule

// ===== hdl/hpfc_drive.sv =====
// P scaling by a tenth, PD sums and pulse saturation into the result register.
// Depends on hpfc_pkg.
module hpfc_drive (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 err_valid,
   output logic                                 err_ready,
   input  hpfc_pkg::err_stage_type              err_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [hpfc_pkg::PULSE_W-1:0]         rsp_right_pulse,
   output logic [hpfc_pkg::PULSE_W-1:0]         rsp_left_pulse,
   output logic signed [hpfc_pkg::HEADING_W-1:0] rsp_heading_error,
   output logic signed [hpfc_pkg::HEADING_W-1:0] rsp_target_shift
);
   import hpfc_pkg::*;

   function automatic logic [PULSE_W-1:0] clamp_pulse(input logic signed [SUM_W-1:0] v);
      logic [PULSE_W-1:0] r;
      if (v < SUM_W'(PULSE_MIN)) begin
         r = PULSE_W'(PULSE_MIN);
      end else if (v > SUM_W'(PULSE_MAX)) begin
         r = PULSE_W'(PULSE_MAX);
      end else begin
         r = v[PULSE_W-1:0];
      end
      return r;
   endfunction

   localparam int QPROD_W = 2 * PMAG_W;
   localparam int Q_W     = QPROD_W - RECIP_TEN_SHIFT;

   logic                        out_v_ff, out_v_in, out_load;
   logic [PULSE_W-1:0]          right_ff, left_ff;
   logic signed [HEADING_W-1:0] error_ff, shift_ff;

   logic [QPROD_W-1:0]          q_prod;
   logic [Q_W-1:0]              q;
   logic signed [SUM_W-1:0]     p_val, p_term, right_sum, left_sum;

   assign err_ready = !out_v_ff || rsp_ready;
   assign out_load  = err_valid && err_ready;
   assign out_v_in  = out_load ? 1'b1 : (rsp_ready ? 1'b0 : out_v_ff);

   always_comb begin
      q_prod    = QPROD_W'(err_data.p_mag) * QPROD_W'(RECIP_TEN);
      q         = q_prod[QPROD_W-1:RECIP_TEN_SHIFT];
      p_val     = SUM_W'(q);
      p_term    = err_data.p_neg ? -p_val : p_val;
      right_sum = SUM_W'(PULSE_NEUTRAL) + p_term + SUM_W'(err_data.d_term);
      left_sum  = SUM_W'(PULSE_NEUTRAL) - p_term + SUM_W'(err_data.d_term);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else begin
         out_v_ff <= out_v_in;
      end
      if (out_load) begin
         right_ff <= clamp_pulse(right_sum);
         left_ff  <= clamp_pulse(left_sum);
         error_ff <= err_data.heading_error;
         shift_ff <= err_data.target_shift;
      end
   end

   assign rsp_valid         = out_v_ff;
   assign rsp_right_pulse   = right_ff;
   assign rsp_left_pulse    = left_ff;
   assign rsp_heading_error = error_ff;
   assign rsp_target_shift  = shift_ff;

   a_right_saturated : assert property (@(posedge clock) disable iff (reset)
      out_v_ff |-> (right_ff >= 12'd2000 && right_ff <= 12'd3500))
      else $error("right pulse outside saturation band");

   a_left_saturated : assert property (@(posedge clock) disable iff (reset)
      out_v_ff |-> (left_ff >= 12'd2000 && left_ff <= 12'd3500))
      else $error("left pulse outside saturation band");

endmodule
